FILE: hdl/alarm_zone_entry_delay_unit_defines.svh
// Assertion macros for the alarm zone entry-delay unit.
`ifndef ALARM_ZONE_ENTRY_DELAY_UNIT_DEFINES_SVH
`define ALARM_ZONE_ENTRY_DELAY_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define AZED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define AZED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/azed_pkg.sv
// Package: codes, constants and stage types for the alarm zone entry-delay unit.
`timescale 1ns / 1ps

package azed_pkg;

  // Item actions
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_REPORT = 2'd1;
  localparam logic [1:0] ACT_TOGGLE = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // Zone status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ALARM = 2'd1;
  localparam logic [1:0] ST_NOSIG = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  // Configuration register indexes
  localparam logic REG_MIN_HOLD    = 1'b0;
  localparam logic REG_ENTRY_DELAY = 1'b1;

  // Reset values of the configuration registers
  localparam logic [15:0] MIN_HOLD_RST    = 16'd1000;
  localparam logic [19:0] ENTRY_DELAY_RST = 20'd30000;

  // Divide by 1000: drop three bits, then multiply by ceil(2^24/125) and shift
  localparam logic [17:0] DIV125_K     = 18'd134218;
  localparam int          DIV125_SHIFT = 24;

  // Word after the state update
  typedef struct packed {
    logic        armed;
    logic        tv;
    logic [31:0] elapsed;
    logic        seen;
    logic [1:0]  first;
  } b_stage_t;

  // Word with the remaining delay in milliseconds
  typedef struct packed {
    logic        armed;
    logic        tv;
    logic [19:0] rem_ms;
    logic        seen;
    logic [1:0]  first;
  } c_stage_t;

endpackage

FILE: hdl/alarm_zone_entry_delay_unit.sv
// Top level: alarm panel core with zone status, arming and entry-delay countdown.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------
//  in      | in_action, in_zone, in_zone_status      | in_valid/in_stall
//  out     | out_armed .. out_first_alarm_zone       | out_valid/out_stall
//  cfg     | cfg_index, cfg_wdata                    | cfg_we, no wait
//
// One word per cycle sustained while out_stall is low; each word passes through the
// four-register chain: input, state update, delay subtract, divide.
// Synchronous active-low reset clears the valid bits, panel state and configuration to defaults.
// Each stage moves on when the one after it is empty or moving, so a stalled
// output fills the chain before in_stall rises.
`timescale 1ns / 1ps
`include "alarm_zone_entry_delay_unit_defines.svh"

module alarm_zone_entry_delay_unit
  import azed_pkg::*;
#(
  parameter int ZONES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_zone,
  input  logic [1:0]  in_zone_status,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_armed,
  output logic        out_trigger_pending,
  output logic [10:0] out_seconds_left,
  output logic        out_alarm_seen,
  output logic [1:0]  out_first_alarm_zone,
  // configuration port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata
);

  // configuration registers
  logic [15:0] min_hold_r;
  logic [19:0] entry_delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_hold_r    <= MIN_HOLD_RST;
      entry_delay_r <= ENTRY_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_HOLD:    min_hold_r    <= cfg_wdata[15:0];
        REG_ENTRY_DELAY: entry_delay_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // pipeline flow control
  logic a_v_r, b_v_r, c_v_r, d_v_r;
  logic a_adv, b_adv, c_adv, d_adv;

  assign d_adv    = !d_v_r || !out_stall;
  assign c_adv    = !c_v_r || d_adv;
  assign b_adv    = !b_v_r || c_adv;
  assign a_adv    = !a_v_r || b_adv;
  assign in_stall = !a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (a_adv) a_v_r <= in_valid;
      if (b_adv) b_v_r <= a_v_r;
      if (c_adv) c_v_r <= b_v_r;
      if (d_adv) d_v_r <= c_v_r;
    end
  end

  // input register
  logic [1:0] a_action_r, a_zone_r, a_status_r;

  always_ff @(posedge clk) begin
    if (in_valid && a_adv) begin
      a_action_r <= in_action;
      a_zone_r   <= in_zone;
      a_status_r <= in_zone_status;
    end
  end

  // panel state
  logic [31:0] now_r, now_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;   // now minus trigger time
  logic        tv_r, tv_nxt;
  logic        armed_r, armed_nxt;
  logic [1:0]  zs_r  [ZONES];
  logic [1:0]  zs_nxt[ZONES];
  logic [31:0] act_r  [ZONES];
  logic [31:0] act_nxt[ZONES];
  logic        a_fire;
  logic        seen_nxt;
  logic [1:0]  first_nxt;

  assign a_fire = a_v_r && b_adv;

  // state update for the word in the input register
  always_comb begin
    logic        set_trig;
    logic        hit;
    logic        faulted;
    logic        ignore;
    logic        apply;
    logic [31:0] age;
    set_trig  = 1'b0;
    now_nxt   = now_r;
    armed_nxt = armed_r;
    tv_nxt    = tv_r;
    for (int i = 0; i < ZONES; i++) begin
      zs_nxt[i]  = zs_r[i];
      act_nxt[i] = act_r[i];
      hit     = a_action_r == ACT_REPORT && a_status_r != ST_BAD &&
                {2'b00, a_zone_r} == 4'(i);
      faulted = zs_r[i] == ST_ALARM || zs_r[i] == ST_NOSIG;
      age     = now_r - act_r[i];
      ignore  = faulted && ((a_status_r == ST_OK && age < {16'd0, min_hold_r}) ||
                            (a_status_r != ST_OK && a_status_r == zs_r[i]));
      apply   = hit && !ignore;
      if (apply) zs_nxt[i] = a_status_r;
      if (apply && a_status_r != ST_OK && armed_r) begin
        act_nxt[i] = now_r;
        set_trig   = 1'b1;
      end
    end
    case (a_action_r)
      ACT_TICK:   now_nxt   = now_r + 32'd1;
      ACT_TOGGLE: armed_nxt = !armed_r;
      ACT_CLEAR:  tv_nxt    = 1'b0;
      default:    ;
    endcase
    if (set_trig) begin
      tv_nxt      = 1'b1;
      elapsed_nxt = '0;
    end else if (a_action_r == ACT_TICK) begin
      elapsed_nxt = elapsed_r + 32'd1;
    end else begin
      elapsed_nxt = elapsed_r;
    end
  end

  // lowest zone in alarm after the update
  always_comb begin
    seen_nxt  = 1'b0;
    first_nxt = '0;
    for (int i = ZONES - 1; i >= 0; i--) begin
      if (zs_nxt[i] == ST_ALARM) begin
        seen_nxt  = 1'b1;
        first_nxt = 2'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r     <= '0;
      elapsed_r <= '0;
      tv_r      <= 1'b0;
      armed_r   <= 1'b0;
      for (int i = 0; i < ZONES; i++) begin
        zs_r[i]  <= ST_OK;
        act_r[i] <= '0;
      end
    end else if (a_fire) begin
      now_r     <= now_nxt;
      elapsed_r <= elapsed_nxt;
      tv_r      <= tv_nxt;
      armed_r   <= armed_nxt;
      for (int i = 0; i < ZONES; i++) begin
        zs_r[i]  <= zs_nxt[i];
        act_r[i] <= act_nxt[i];
      end
    end
  end

  // stage B: snapshot after the update
  b_stage_t b_r;

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_r.armed   <= armed_nxt;
      b_r.tv      <= tv_nxt;
      b_r.elapsed <= elapsed_nxt;
      b_r.seen    <= seen_nxt;
      b_r.first   <= first_nxt;
    end
  end

  // stage C: remaining delay in milliseconds, zero once expired or with no trigger pending
  c_stage_t c_r;
  logic     b_live;

  assign b_live = b_r.tv && b_r.elapsed < {12'd0, entry_delay_r};

  always_ff @(posedge clk) begin
    if (b_v_r && c_adv) begin
      c_r.armed  <= b_r.armed;
      c_r.tv     <= b_r.tv;
      c_r.rem_ms <= b_live ? entry_delay_r - b_r.elapsed[19:0] : '0;
      c_r.seen   <= b_r.seen;
      c_r.first  <= b_r.first;
    end
  end

  // stage D: whole seconds by reciprocal multiply
  logic [34:0] sec_prod;
  logic [10:0] sec_r;
  logic        d_armed_r, d_tv_r, d_seen_r;
  logic [1:0]  d_first_r;

  assign sec_prod = {1'b0, c_r.rem_ms[19:3]} * {17'd0, DIV125_K};

  always_ff @(posedge clk) begin
    if (c_v_r && d_adv) begin
      sec_r     <= sec_prod[DIV125_SHIFT +: 11];
      d_armed_r <= c_r.armed;
      d_tv_r    <= c_r.tv;
      d_seen_r  <= c_r.seen;
      d_first_r <= c_r.first;
    end
  end

  assign out_valid            = d_v_r;
  assign out_armed            = d_armed_r;
  assign out_trigger_pending  = d_tv_r;
  assign out_seconds_left     = sec_r;
  assign out_alarm_seen       = d_seen_r;
  assign out_first_alarm_zone = d_first_r;

  // checks
  `AZED_ASSERT_NEXT(a_clear_drops_trigger, a_fire && a_action_r == ACT_CLEAR, !b_r.tv,
                    "clear action left trigger pending")
  `AZED_ASSERT_NOW(a_rem_needs_trigger, c_v_r && c_r.rem_ms != 20'd0, c_r.tv,
                   "delay remaining without a trigger")
  `AZED_ASSERT_NOW(a_stall_only_when_full, in_stall, a_v_r && b_v_r && c_v_r && d_v_r,
                   "input stalled with a free stage")

endmodule

FILE: verif/alarm_zone_entry_delay_unit_test.sv
// Self-checking testbench for the alarm zone entry-delay unit with its own predictor.
`timescale 1ns / 1ps

module alarm_zone_entry_delay_unit_test;
  import azed_pkg::*;

  localparam int NUM_ZONES   = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_PRINTS  = 200;
  localparam logic [31:0] MS_PER_SEC = 32'd1000;

  // One result word, laid out like the output ports
  typedef struct packed {
    logic        armed;
    logic        trigger_pending;
    logic [10:0] seconds_left;
    logic        alarm_seen;
    logic [1:0]  first_alarm_zone;
  } alarm_word_t;

  // Tracks the panel state and holds the words still to come out
  class panel_scoreboard;
    logic [15:0] min_hold;
    logic [19:0] entry_delay;
    logic [31:0] now_ms;
    logic [1:0]  zone_st [NUM_ZONES];
    logic [31:0] stamp [NUM_ZONES];
    logic [31:0] trig_time;
    bit          trig_valid;
    bit          armed;
    alarm_word_t expected_words [$];
    int          errors;
    int          checked;

    function new();
      min_hold    = MIN_HOLD_RST;
      entry_delay = ENTRY_DELAY_RST;
      now_ms      = '0;
      for (int i = 0; i < NUM_ZONES; i++) begin
        zone_st[i] = ST_OK;
        stamp[i]   = '0;
      end
      trig_time  = '0;
      trig_valid = 1'b0;
      armed      = 1'b0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic idx, logic [19:0] val);
      if (idx == REG_MIN_HOLD) begin
        min_hold = val[15:0];
      end else begin
        entry_delay = val;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Apply one accepted input word and queue the word it should produce
    function void apply_action(logic [1:0] act, logic [1:0] zn, logic [1:0] st);
      alarm_word_t w;
      logic [31:0] held;
      logic [31:0] elapsed;
      bit          ignore;
      case (act)
        ACT_TICK: begin
          now_ms = now_ms + 32'd1;
        end
        ACT_REPORT: begin
          // out-of-range zones and status three are dropped
          if (zn < NUM_ZONES && st != ST_BAD) begin
            ignore = 1'b0;
            if (zone_st[zn] != ST_OK) begin
              held = now_ms - stamp[zn];
              if (st == ST_OK) begin
                ignore = (held < {16'd0, min_hold});
              end else begin
                ignore = (st == zone_st[zn]);
              end
            end
            if (!ignore) begin
              // a fault while armed stamps the zone and restarts the countdown
              if (st != ST_OK && armed) begin
                stamp[zn]  = now_ms;
                trig_time  = now_ms;
                trig_valid = 1'b1;
              end
              zone_st[zn] = st;
            end
          end
        end
        ACT_TOGGLE: begin
          armed = !armed;
        end
        default: begin
          trig_valid = 1'b0;
        end
      endcase

      w.armed           = armed;
      w.trigger_pending = trig_valid;
      elapsed           = now_ms - trig_time;
      if (trig_valid && elapsed < {12'd0, entry_delay}) begin
        w.seconds_left = 11'(({12'd0, entry_delay} - elapsed) / MS_PER_SEC);
      end else begin
        w.seconds_left = '0;
      end
      // lowest zone in alarm wins, so scan downwards
      w.alarm_seen       = 1'b0;
      w.first_alarm_zone = '0;
      for (int i = NUM_ZONES - 1; i >= 0; i--) begin
        if (zone_st[i] == ST_ALARM) begin
          w.alarm_seen       = 1'b1;
          w.first_alarm_zone = 2'(i);
        end
      end
      expected_words.push_back(w);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("[%0t] word %0d: %s got %0d, expected %0d", $time, checked, what, got, want);
    endtask

    task check_word(alarm_word_t got);
      alarm_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, armed", got.armed, -1);
      end else begin
        want = expected_words.pop_front();
        if (got.armed !== want.armed)
          report_mismatch("armed", got.armed, want.armed);
        if (got.trigger_pending !== want.trigger_pending)
          report_mismatch("trigger_pending", got.trigger_pending, want.trigger_pending);
        if (got.seconds_left !== want.seconds_left)
          report_mismatch("seconds_left", got.seconds_left, want.seconds_left);
        if (got.alarm_seen !== want.alarm_seen)
          report_mismatch("alarm_seen", got.alarm_seen, want.alarm_seen);
        if (got.first_alarm_zone !== want.first_alarm_zone)
          report_mismatch("first_alarm_zone", got.first_alarm_zone, want.first_alarm_zone);
      end
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_TICK;
  logic [1:0]  in_zone = 2'd0;
  logic [1:0]  in_zone_status = ST_OK;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_armed;
  logic        out_trigger_pending;
  logic [10:0] out_seconds_left;
  logic        out_alarm_seen;
  logic [1:0]  out_first_alarm_zone;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_MIN_HOLD;
  logic [19:0] cfg_wdata = '0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          pressure_req = 0;
  int          pressure_taken = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  alarm_word_t out_word;

  panel_scoreboard panel = new();

  assign out_word = {out_armed, out_trigger_pending, out_seconds_left,
                     out_alarm_seen, out_first_alarm_zone};

  alarm_zone_entry_delay_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_zone              (in_zone),
    .in_zone_status       (in_zone_status),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_armed            (out_armed),
    .out_trigger_pending  (out_trigger_pending),
    .out_seconds_left     (out_seconds_left),
    .out_alarm_seen       (out_alarm_seen),
    .out_first_alarm_zone (out_first_alarm_zone),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (pressure_taken != pressure_req) begin
      pressure_taken <= pressure_req;
      hold_left      <= HOLD_CYCLES;
      out_stall      <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor both channels at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        panel.apply_action(in_action, in_zone, in_zone_status);
      if (out_valid && !out_stall)
        panel.check_word(out_word);
    end
  end

  function automatic logic [1:0] any2();
    return 2'($urandom_range(3));
  endfunction

  // Offer one word, with a random gap first, and wait until it is taken
  task automatic send_word(input logic [1:0] act, input logic [1:0] zn,
                           input logic [1:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_zone        <= zn;
    in_zone_status <= st;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain the block so the registers can be rewritten
  task automatic settle();
    in_valid <= 1'b0;
    while (panel.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] hold, input logic [19:0] delay);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_HOLD;
    cfg_wdata <= {4'd0, hold};
    @(posedge clk);
    panel.set_reg(REG_MIN_HOLD, {4'd0, hold});
    cfg_index <= REG_ENTRY_DELAY;
    cfg_wdata <= delay;
    @(posedge clk);
    panel.set_reg(REG_ENTRY_DELAY, delay);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic: tick bursts move time on, reports mostly in range
  task automatic run_random(input int items);
    int sent;
    int pick;
    int burst;
    logic [1:0] zn;
    logic [1:0] st;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        burst = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
        repeat (burst) send_word(ACT_TICK, any2(), any2());
        sent += burst;
      end else begin
        if (pick < 75) begin
          zn = ($urandom_range(11) == 0) ? 2'd3 : 2'($urandom_range(NUM_ZONES - 1));
          st = ($urandom_range(11) == 0) ? ST_BAD : 2'($urandom_range(2));
          send_word(ACT_REPORT, zn, st);
        end else if (pick < 85) begin
          send_word(ACT_TOGGLE, any2(), any2());
        end else begin
          send_word(ACT_CLEAR, any2(), any2());
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short hold and a delay just over two seconds
    send_idle_pct = 22;
    recv_idle_pct = 45;
    write_regs(16'd3, 20'd2001);
    send_word(ACT_TICK, 2'd3, ST_BAD);
    send_word(ACT_REPORT, 2'd0, ST_ALARM);   // fault while disarmed, no stamp
    send_word(ACT_REPORT, 2'd0, ST_OK);      // still inside the hold time
    send_word(ACT_TOGGLE, 2'd0, ST_OK);
    send_word(ACT_REPORT, 2'd1, ST_NOSIG);   // armed fault starts the countdown
    send_word(ACT_REPORT, 2'd1, ST_NOSIG);   // repeated fault
    send_word(ACT_REPORT, 2'd2, ST_ALARM);
    send_word(ACT_REPORT, 2'd3, ST_ALARM);   // zone out of range
    send_word(ACT_REPORT, 2'd0, ST_BAD);     // status three
    send_word(ACT_REPORT, 2'd1, ST_OK);      // hold not yet over
    repeat (2) send_word(ACT_TICK, 2'd0, ST_OK);
    send_word(ACT_REPORT, 2'd1, ST_OK);      // one short of the hold time
    send_word(ACT_TICK, 2'd2, ST_NOSIG);
    send_word(ACT_REPORT, 2'd1, ST_OK);      // hold time reached exactly
    send_word(ACT_REPORT, 2'd0, ST_OK);
    send_word(ACT_REPORT, 2'd2, ST_NOSIG);   // change of fault kind
    send_word(ACT_REPORT, 2'd1, ST_ALARM);
    send_word(ACT_CLEAR, 2'd0, ST_OK);
    send_word(ACT_TOGGLE, 2'd0, ST_OK);
    send_word(ACT_REPORT, 2'd0, ST_NOSIG);   // fault while disarmed
    send_word(ACT_REPORT, 2'd2, ST_OK);
    settle();

    // Phase one: both registers at their lowest
    write_regs(16'd0, 20'd0);
    run_random(150);
    settle();

    // Phase two: idling swapped, registers at their highest, one long hold-off
    send_idle_pct = 45;
    recv_idle_pct = 22;
    write_regs(16'hFFFF, 20'hFFFFF);
    pressure_req <= pressure_req + 1;
    run_random(150);
    settle();

    // Phase three: no idling, delay near a whole second boundary
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_regs(16'($urandom_range(40)), 20'(1000 * $urandom_range(5, 1) + $urandom_range(20)));
    pressure_req <= pressure_req + 1;
    run_random(150);
    settle();

    // Phase four: reset-value registers with mixed idling
    send_idle_pct = 22;
    recv_idle_pct = 45;
    write_regs(MIN_HOLD_RST, ENTRY_DELAY_RST);
    run_random(150);
    settle();

    if (panel.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
